/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the gesture trigger checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define CVGT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CVGT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/cvgt_pkg.sv */
// ----------------------------------------------------------------------------
// Gesture trigger package
// Widths, register indexes, action codes and reset values of the trigger.
// ----------------------------------------------------------------------------
package cvgt_pkg;

  localparam int unsigned CLK_W      = 32;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned ACT_W      = 2;

  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned CROSS_W = 33;
  localparam int unsigned D2_W    = 34;
  localparam int unsigned TSQ_W   = 2 * THR_W;
  localparam int unsigned OPND_W  = 35;
  localparam int unsigned PROD_W  = 2 * OPND_W;
  localparam int unsigned CMP_W   = 67;
  localparam int unsigned STEP_W  = 5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ACT_W-1:0] action_t;

  localparam logic [CFG_ADDR_W-1:0] REG_TICK_DIV  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_START_THR = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STOP_THR  = 2'd2;

  localparam action_t ACT_NONE    = 2'd0;
  localparam action_t ACT_RESTART = 2'd1;
  localparam action_t ACT_STOP    = 2'd2;

  localparam logic [THR_W-1:0] TICK_DIV_RST  = 16'd1;
  localparam logic [THR_W-1:0] START_THR_RST = 16'd1500;
  localparam logic [THR_W-1:0] STOP_THR_RST  = 16'd110;

endpackage

/* rtl/cvgt_in_if.sv */
// ----------------------------------------------------------------------------
// Gesture trigger input channel
// One tick request: counter value, valid flags, velocity and positions.
// ----------------------------------------------------------------------------
interface cvgt_in_if;
  import cvgt_pkg::*;

  logic             valid;
  logic             ready;
  logic [CLK_W-1:0] clock_count;
  logic             joint_valid;
  logic             anchor_valid;
  coord_t           vel_x;
  coord_t           vel_y;
  coord_t           vel_z;
  coord_t           pos_x;
  coord_t           pos_y;
  coord_t           pos_z;
  coord_t           anchor_x;
  coord_t           anchor_y;
  coord_t           anchor_z;

  modport source (
    output valid, clock_count, joint_valid, anchor_valid,
    output vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, anchor_x, anchor_y, anchor_z,
    input  ready
  );

  modport sink (
    input  valid, clock_count, joint_valid, anchor_valid,
    input  vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, anchor_x, anchor_y, anchor_z,
    output ready
  );

  modport monitor (
    input valid, ready, clock_count, joint_valid, anchor_valid,
    input vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, anchor_x, anchor_y, anchor_z
  );

endinterface

/* rtl/cvgt_out_if.sv */
// ----------------------------------------------------------------------------
// Gesture trigger result channel
// One result request per tick: action code and the playing flag.
// ----------------------------------------------------------------------------
interface cvgt_out_if;
  import cvgt_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  logic    playing_now;

  modport source (
    output valid, action, playing_now,
    input  ready
  );

  modport sink (
    input  valid, action, playing_now,
    output ready
  );

  modport monitor (
    input valid, ready, action, playing_now
  );

endinterface

/* rtl/cross_velocity_gesture_trigger_top.sv */
// ----------------------------------------------------------------------------
// Cross velocity gesture trigger
// Each request passes through the accept, 17 sequencer steps around the one shared
// 35x35 multiplier and the result load; a new request is taken only after the
// result load returns the sequencer to idle. A stalled result holds the block longer.
// Synchronous active-low reset idles the sequencer, clears the playing flag and
// the result valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module cross_velocity_gesture_trigger_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cvgt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [cvgt_pkg::THR_W-1:0]          cfg_wdata,
  cvgt_in_if.sink                             in_if,
  cvgt_out_if.source                          out_if
);
  import cvgt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [STEP_W-1:0] STEP_LAST = 5'd16;

  logic [THR_W-1:0]  tick_div_r;
  logic [THR_W-1:0]  start_thr_r;
  logic [THR_W-1:0]  stop_thr_r;
  logic              playing_r;

  logic [1:0]        state_r;
  logic [1:0]        state_nxt;
  logic [STEP_W-1:0] step_r;

  logic [CLK_W-1:0]  clk_sh_r;
  logic              jv_r;
  logic              av_r;
  coord_t            vel_x_r, vel_y_r, vel_z_r;
  coord_t            pos_x_r, pos_y_r, pos_z_r;
  coord_t            anc_x_r, anc_y_r, anc_z_r;

  logic [THR_W-1:0]  rem_r;
  logic signed [PROD_W-1:0]  p_r;
  logic signed [PROD_W-1:0]  acc_r;
  logic signed [CROSS_W-1:0] cx_r, cy_r, cz_r;
  logic [D2_W-1:0]   d2_r;
  logic [TSQ_W-1:0]  ts_r;
  logic [TSQ_W-1:0]  tp_r;
  logic [CMP_W-1:0]  c2_r;
  logic              gt_r;
  logic              lt_r;

  logic              out_valid_r;
  action_t           out_action_r;
  logic              out_playing_r;

  logic                      in_fire;
  logic                      out_load;
  logic signed [DIFF_W-1:0]  dx, dy, dz;
  logic signed [OPND_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0]  acc_sum, acc_dif;
  logic [THR_W:0]            dv;
  logic [THR_W:0]            t1, t2;
  logic [THR_W-1:0]          r1, r2;
  logic                      eval_ok;
  logic                      cx_pos;
  logic                      start_hit;
  logic                      stop_hit;

  assign in_if.ready = rst_n && (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_load    = (state_r == ST_FIN) && (!out_valid_r || out_if.ready);

  assign dx = DIFF_W'(pos_x_r) - DIFF_W'(anc_x_r);
  assign dy = DIFF_W'(pos_y_r) - DIFF_W'(anc_y_r);
  assign dz = DIFF_W'(pos_z_r) - DIFF_W'(anc_z_r);

  // Remainder of the tick count, two dividend bits per cycle.
  assign dv = (tick_div_r == '0) ? (THR_W+1)'(1) : {1'b0, tick_div_r};
  assign t1 = {rem_r, clk_sh_r[CLK_W-1]};
  assign r1 = (t1 >= dv) ? THR_W'(t1 - dv) : t1[THR_W-1:0];
  assign t2 = {r1, clk_sh_r[CLK_W-2]};
  assign r2 = (t2 >= dv) ? THR_W'(t2 - dv) : t2[THR_W-1:0];

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_r)
      5'd0:  begin op_a = OPND_W'(vel_y_r);     op_b = OPND_W'(dz); end
      5'd1:  begin op_a = OPND_W'(vel_z_r);     op_b = OPND_W'(dy); end
      5'd2:  begin op_a = OPND_W'(vel_z_r);     op_b = OPND_W'(dx); end
      5'd3:  begin op_a = OPND_W'(vel_x_r);     op_b = OPND_W'(dz); end
      5'd4:  begin op_a = OPND_W'(vel_x_r);     op_b = OPND_W'(dy); end
      5'd5:  begin op_a = OPND_W'(vel_y_r);     op_b = OPND_W'(dx); end
      5'd6:  begin op_a = OPND_W'(dx);          op_b = OPND_W'(dx); end
      5'd7:  begin op_a = OPND_W'(dy);          op_b = OPND_W'(dy); end
      5'd8:  begin op_a = OPND_W'(dz);          op_b = OPND_W'(dz); end
      5'd9:  begin op_a = OPND_W'(start_thr_r); op_b = OPND_W'(start_thr_r); end
      5'd10: begin op_a = OPND_W'(stop_thr_r);  op_b = OPND_W'(stop_thr_r); end
      5'd11: begin op_a = OPND_W'(cx_r);        op_b = OPND_W'(cx_r); end
      5'd12: begin op_a = OPND_W'(cy_r);        op_b = OPND_W'(cy_r); end
      5'd13: begin op_a = OPND_W'(cz_r);        op_b = OPND_W'(cz_r); end
      5'd14: begin op_a = OPND_W'(ts_r);        op_b = OPND_W'(d2_r); end
      5'd15: begin op_a = OPND_W'(tp_r);        op_b = OPND_W'(d2_r); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign acc_sum = acc_r + p_r;
  assign acc_dif = acc_r - p_r;

  assign eval_ok   = (rem_r == '0) && jv_r && av_r && !(dx == '0 && dy == '0 && dz == '0);
  assign cx_pos    = !cx_r[CROSS_W-1] && (cx_r != '0);
  assign start_hit = eval_ok && gt_r && cx_pos && !playing_r;
  assign stop_hit  = eval_ok && !start_hit && lt_r && playing_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) begin
        state_nxt = ST_RUN;
      end
      ST_RUN: if (step_r == STEP_LAST) begin
        state_nxt = ST_FIN;
      end
      ST_FIN: if (out_load) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_div_r  <= TICK_DIV_RST;
      start_thr_r <= START_THR_RST;
      stop_thr_r  <= STOP_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TICK_DIV:  tick_div_r  <= cfg_wdata;
        REG_START_THR: start_thr_r <= cfg_wdata;
        REG_STOP_THR:  stop_thr_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      playing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        step_r <= '0;
      end else if (state_r == ST_RUN) begin
        step_r <= step_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (start_hit) begin
          playing_r <= 1'b1;
        end else if (stop_hit) begin
          playing_r <= 1'b0;
        end
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      clk_sh_r <= in_if.clock_count;
      jv_r     <= in_if.joint_valid;
      av_r     <= in_if.anchor_valid;
      vel_x_r  <= in_if.vel_x;
      vel_y_r  <= in_if.vel_y;
      vel_z_r  <= in_if.vel_z;
      pos_x_r  <= in_if.pos_x;
      pos_y_r  <= in_if.pos_y;
      pos_z_r  <= in_if.pos_z;
      anc_x_r  <= in_if.anchor_x;
      anc_y_r  <= in_if.anchor_y;
      anc_z_r  <= in_if.anchor_z;
      rem_r    <= '0;
    end else if (state_r == ST_RUN && !step_r[STEP_W-1]) begin
      clk_sh_r <= clk_sh_r << 2;
      rem_r    <= r2;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RUN) begin
      p_r <= op_a * op_b;
      unique case (step_r)
        5'd1, 5'd3, 5'd5, 5'd7, 5'd12: acc_r <= p_r;
        5'd8, 5'd13: acc_r <= acc_sum;
        5'd2:  cx_r <= acc_dif[CROSS_W-1:0];
        5'd4:  cy_r <= acc_dif[CROSS_W-1:0];
        5'd6:  cz_r <= acc_dif[CROSS_W-1:0];
        5'd9:  d2_r <= acc_sum[D2_W-1:0];
        5'd10: ts_r <= p_r[TSQ_W-1:0];
        5'd11: tp_r <= p_r[TSQ_W-1:0];
        5'd14: c2_r <= acc_sum[CMP_W-1:0];
        5'd15: gt_r <= c2_r > p_r[CMP_W-1:0];
        5'd16: lt_r <= c2_r < p_r[CMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_playing_r <= (playing_r || start_hit) && !stop_hit;
      if (start_hit) begin
        out_action_r <= ACT_RESTART;
      end else if (stop_hit) begin
        out_action_r <= ACT_STOP;
      end else begin
        out_action_r <= ACT_NONE;
      end
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.action      = out_action_r;
  assign out_if.playing_now = out_playing_r;

endmodule

/* rtl/cvgt_checker.sv */
// ----------------------------------------------------------------------------
// Gesture trigger checker
// Port-level checks on the request channels of the trigger top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cvgt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input cvgt_pkg::action_t out_action,
  input logic              out_playing_now
);
  import cvgt_pkg::*;

  logic           in_take;
  logic           out_stall;
  logic           out_restart;
  logic           out_stop;
  logic [ACT_W:0] out_word;

  assign in_take     = in_valid && in_ready;
  assign out_stall   = out_valid && !out_ready;
  assign out_restart = out_valid && (out_action == ACT_RESTART);
  assign out_stop    = out_valid && (out_action == ACT_STOP);
  assign out_word    = {out_action, out_playing_now};

  `CVGT_ASSERT(a_out_hold, out_stall |=> out_valid, "result request dropped while stalled")
  `CVGT_ASSERT(a_out_stable, out_stall |=> $stable(out_word), "stalled result changed")
  `CVGT_ASSERT(a_restart_flag, out_restart |-> out_playing_now, "restart without playing flag")
  `CVGT_ASSERT(a_stop_flag, out_stop |-> !out_playing_now, "stop with playing flag still set")
  `CVGT_ASSERT_ALWAYS(a_busy, in_take |=> !in_ready, "second request taken while busy")

endmodule

bind cross_velocity_gesture_trigger_top cvgt_checker u_cvgt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_action      (out_if.action),
  .out_playing_now (out_if.playing_now)
);
